[rtl/timer_entropy_pool_mixer_top_assert.svh]
// Assertion macros used by the entropy pool mixer core (tepm_core).
`ifndef TIMER_ENTROPY_POOL_MIXER_TOP_ASSERT_SVH
`define TIMER_ENTROPY_POOL_MIXER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TEPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TEPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/tepm_pkg.sv]
package tepm_pkg;

  // Operation codes.
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_SEEDED   = 2'd1;
  localparam logic [1:0] ST_SEED_IGNORED = 2'd2;

  // Mixing constants.
  localparam logic [31:0] MIX_RESET  = 32'h5A5A_5A5A;
  localparam logic [31:0] GOLDEN     = 32'h9E37_79B9;
  localparam int          LOOK_AHEAD = 3;

  typedef struct packed {
    logic        operation;
    logic [31:0] sample_first;
    logic [31:0] sample_second;
  } in_item_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic        pool_ready;
    logic [1:0]  status;
  } out_item_t;

  // One xorshift32 round.
  function automatic logic [31:0] xs32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // Swap the two halves of a word.
  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

[rtl/timer_entropy_pool_mixer_top.sv]
// Timer-jitter entropy pool with an xorshift32 mixer.
// Input channel (in_valid / in_ready / in_data) carries one item per transfer:
// a seed item folds two timer samples into the next pool word, a draw item
// stirs one timer sample into the pool and returns a fresh random word.
// Result channel (out_valid / out_ready / out_data) returns exactly one item
// per input item, in order: the random word (zero unless a draw succeeded),
// the pool-ready flag and a status code.
// An accepted item waits in the input register and moves to the result
// register when that register is free or being emptied.
// Throughput: one item per cycle unless the receiver stalls. All mixing
// for an item is done in the cycle it moves from the input register to the
// result register. Reset (rst_n low, synchronous) loads the mixing state
// constant, clears the seed count (pool words are kept) and both valid
// flags; draws are refused until POOL_WORDS seeds have been taken.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item, then in_ready drops until the result
// is transferred.
module timer_entropy_pool_mixer_top
  import tepm_pkg::*;
#(
  parameter int POOL_WORDS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      in_valid_r;
  logic      in_valid_nxt;
  in_item_t  in_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_r;
  out_item_t core_result;
  logic      advance;

  // An item moves to the result register when that register is free or its item leaves.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  tepm_core #(
    .POOL_WORDS(POOL_WORDS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_r),
    .result (core_result)
  );

  // Valid flags of the two registers.
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/tepm_core.sv]
`include "timer_entropy_pool_mixer_top_assert.svh"

module tepm_core
  import tepm_pkg::*;
#(
  parameter int POOL_WORDS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int CW    = $clog2(POOL_WORDS + 1);
  localparam int Q_TAP = (1 + LOOK_AHEAD) % POOL_WORDS;

  // The pool is kept as a rotating line: slot k holds the word at the
  // current position plus k, so both draw reads are fixed taps.
  logic [31:0]   pool_r   [POOL_WORDS];
  logic [31:0]   pool_nxt [POOL_WORDS];
  logic [31:0]   mix_r;
  logic [31:0]   mix_nxt;
  logic [CW-1:0] seed_cnt_r;
  logic [CW-1:0] seed_cnt_nxt;

  logic        is_ready;
  logic        seed_ok;
  logic        draw_ok;
  logic [31:0] seed_word;
  logic [31:0] sel_word;
  logic [31:0] st1;
  logic [31:0] st2;
  logic [31:0] remix;

  assign is_ready = (seed_cnt_r == CW'(POOL_WORDS));
  assign seed_ok  = (item.operation == OP_SEED) && !is_ready;
  assign draw_ok  = (item.operation == OP_DRAW) && is_ready;

  // Seed word: samples folded together with the index times the golden ratio.
  assign seed_word = item.sample_first ^ rot16(item.sample_second)
                   ^ 32'(32'(seed_cnt_r) * GOLDEN);

  // Draw path: absorb the sample, mix twice, then remix the selected word.
  assign sel_word = pool_r[1] ^ item.sample_first;
  assign st1      = xs32(mix_r ^ sel_word);
  assign st2      = xs32(st1 ^ pool_r[Q_TAP]);
  assign remix    = xs32(sel_word ^ st2);

  // Next state of the pool line, mixing state and seed count.
  always_comb begin
    for (int k = 0; k < POOL_WORDS; k++) begin
      pool_nxt[k] = pool_r[k];
    end
    mix_nxt      = mix_r;
    seed_cnt_nxt = seed_cnt_r;
    if (fire && seed_ok) begin
      for (int k = 0; k < POOL_WORDS - 1; k++) begin
        pool_nxt[k] = pool_r[k + 1];
      end
      pool_nxt[POOL_WORDS - 1] = seed_word;
      seed_cnt_nxt             = seed_cnt_r + CW'(1);
    end else if (fire && draw_ok) begin
      pool_nxt[0] = remix;
      for (int k = 1; k < POOL_WORDS - 1; k++) begin
        pool_nxt[k] = pool_r[k + 1];
      end
      pool_nxt[POOL_WORDS - 1] = pool_r[0];
      mix_nxt                  = st2;
    end
  end

  // Result of the item currently presented.
  always_comb begin
    result.random_word = draw_ok ? st2 : 32'd0;
    result.pool_ready  = is_ready || (seed_ok && seed_cnt_r == CW'(POOL_WORDS - 1));
    if (item.operation == OP_DRAW) begin
      result.status = is_ready ? ST_OK : ST_NOT_SEEDED;
    end else begin
      result.status = is_ready ? ST_SEED_IGNORED : ST_OK;
    end
  end

  // Pool words carry no reset; the seed count and mixing state do.
  always_ff @(posedge clk) begin
    for (int k = 0; k < POOL_WORDS; k++) begin
      pool_r[k] <= pool_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r      <= MIX_RESET;
      seed_cnt_r <= '0;
    end else begin
      mix_r      <= mix_nxt;
      seed_cnt_r <= seed_cnt_nxt;
    end
  end

  `TEPM_ASSERT_NEXT(a_refused_keeps_mix, clk, rst_n, fire && !draw_ok, mix_r == $past(mix_r))
  `TEPM_ASSERT_NEXT(a_draw_updates_mix, clk, rst_n, fire && draw_ok, mix_r == $past(st2))
  `TEPM_ASSERT_NOW(a_seed_cnt_bound, clk, rst_n, 1'b1, seed_cnt_r <= CW'(POOL_WORDS))
  `TEPM_ASSERT_NOW(a_error_zero_word, clk, rst_n, result.status != ST_OK,
                   result.random_word == 32'd0)

endmodule
